/* src/zcdp_pkg.sv */
`default_nettype none
package zcdp_pkg;

	// Fixed header layout of a central directory record
	localparam int unsigned HDR_LEN      = 46;
	localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;

	// Record position width and the width of a sum of header and three 16-bit lengths
	localparam int unsigned POS_W = 18;
	localparam int unsigned SUM_W = POS_W + 1;

	// Result queue geometry
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;
	// Highest queue fill at which a byte may be processed (it can push two results)
	localparam int unsigned QMAX_FILL = QDEPTH - 2;

	// Configuration register indexes
	typedef enum logic {
		REG_ENTRY_LIMIT     = 1'b0,
		REG_DIRECTORY_BYTES = 1'b1
	} reg_index_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_NAME    = 3'd1,
		KIND_BAD_SIG = 3'd2,
		KIND_TRUNC   = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	// One result word
	typedef struct packed {
		kind_t       kind;
		logic [15:0] method;
		logic [15:0] dos_time;
		logic [15:0] dos_date;
		logic [31:0] crc_value;
		logic [31:0] packed_size;
		logic [31:0] plain_size;
		logic [15:0] name_len;
		logic [31:0] header_offset;
		logic [7:0]  name_char;
		logic        last_char;
	} result_t;

	// Header fields captured while a record streams in
	typedef struct packed {
		logic [15:0] method;
		logic [15:0] dos_time;
		logic [15:0] dos_date;
		logic [31:0] crc;
		logic [31:0] packed_size;
		logic [31:0] plain_size;
		logic [15:0] name_len;
		logic [15:0] extra_len;
		logic [15:0] comment_len;
		logic [31:0] offset;
	} fields_t;

endpackage
`default_nettype wire

/* src/zcdp_in_if.sv */
`default_nettype none
interface zcdp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

/* src/zcdp_out_if.sv */
`default_nettype none
interface zcdp_out_if;
	logic             valid;
	logic             ready;
	zcdp_pkg::kind_t  kind;
	logic [15:0]      method;
	logic [15:0]      dos_time;
	logic [15:0]      dos_date;
	logic [31:0]      crc_value;
	logic [31:0]      packed_size;
	logic [31:0]      plain_size;
	logic [15:0]      name_len;
	logic [31:0]      header_offset;
	logic [7:0]       name_char;
	logic             last_char;

	modport source (
		output valid, output kind, output method, output dos_time, output dos_date,
		output crc_value, output packed_size, output plain_size, output name_len,
		output header_offset, output name_char, output last_char,
		input ready
	);
	modport sink (
		input valid, input kind, input method, input dos_time, input dos_date,
		input crc_value, input packed_size, input plain_size, input name_len,
		input header_offset, input name_char, input last_char,
		output ready
	);
endinterface
`default_nettype wire

/* src/zip_central_directory_parser_unit.sv */
`default_nettype none
// Channel     Dir  Word                         Handshake
// byte_in     in   data_byte, one directory byte valid/ready
// entry_out   out  one result (header/name/...) valid/ready
// wr_*        in   config write (index, data)   wr_en, no back-pressure
//
// One byte per cycle while the queue has room: a byte is held in the input
// register, is decoded by the position counter and field capture logic, and its
// results enter a 4-deep result queue; a byte enters the queue stage only
// while at least two slots are free. Results leave from the queue registers.
// arst_n clears all control state; a write to entry_limit restarts parsing.
// A stalled entry_out backs up into the queue and then into byte_in.ready.
module zip_central_directory_parser_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire zcdp_pkg::reg_index_t  wr_index,
	input  wire logic [31:0]           wr_data,
	zcdp_in_if.sink                    byte_in,
	zcdp_out_if.source                 entry_out
);
	import zcdp_pkg::*;

	// Configuration registers
	logic [15:0] entry_limit_q;
	logic [31:0] dir_bytes_q;

	// Input register
	logic       v_s1;
	logic [7:0] byte_s1;

	// Parser state
	logic [POS_W-1:0] rec_pos_q, rec_pos_n;
	logic [31:0]      dir_pos_q, dir_pos_n;
	logic [15:0]      ent_q, ent_n;
	logic [31:0]      sig_q, sig_n;
	fields_t          fld_q, fld_n;
	logic             fin_q, fin_n;
	logic             fail_q, fail_n;

	// Result queue
	result_t            q_mem [QDEPTH];
	logic [QPTR_W-1:0]  wp_q, rp_q;
	logic [QCNT_W-1:0]  cnt_q;

	logic        adv, restart, pop;
	logic        va, vb;
	result_t     res_a, res_b, push_first;
	logic [1:0]  npush;

	logic [SUM_W-1:0] pos_w, name_end, total;

	assign restart = wr_en && (wr_index == REG_ENTRY_LIMIT);
	assign adv     = v_s1 && (cnt_q <= QCNT_W'(QMAX_FILL));
	assign byte_in.ready = !v_s1 || adv;
	assign pop     = entry_out.valid && entry_out.ready;

	// Per-byte decode: field capture, counters and result generation
	always_comb begin
		rec_pos_n = rec_pos_q;
		dir_pos_n = dir_pos_q;
		ent_n     = ent_q;
		sig_n     = sig_q;
		fld_n     = fld_q;
		fin_n     = fin_q;
		fail_n    = fail_q;
		va        = 1'b0;
		vb        = 1'b0;
		res_a     = '0;
		res_b     = '0;
		pos_w     = SUM_W'(rec_pos_q);
		name_end  = SUM_W'(HDR_LEN) + SUM_W'(fld_q.name_len);
		total     = '0;

		if (adv && !fin_q && !fail_q) begin
			if (rec_pos_q == '0 && (ent_q >= entry_limit_q || dir_pos_q >= dir_bytes_q)) begin
				fin_n      = 1'b1;
				va         = 1'b1;
				res_a.kind = KIND_DONE;
			end else if (rec_pos_q == POS_W'(3) && {byte_s1, sig_q[31:8]} != CD_SIGNATURE) begin
				sig_n      = {byte_s1, sig_q[31:8]};
				fail_n     = 1'b1;
				va         = 1'b1;
				res_a.kind = KIND_BAD_SIG;
			end else begin
				// capture by byte position inside the fixed header
				if (rec_pos_q[POS_W-1:6] == '0) begin
					unique case (rec_pos_q[5:0])
						6'd0, 6'd1, 6'd2, 6'd3: sig_n = {byte_s1, sig_q[31:8]};
						6'd10: fld_n.method[7:0]       = byte_s1;
						6'd11: fld_n.method[15:8]      = byte_s1;
						6'd12: fld_n.dos_time[7:0]     = byte_s1;
						6'd13: fld_n.dos_time[15:8]    = byte_s1;
						6'd14: fld_n.dos_date[7:0]     = byte_s1;
						6'd15: fld_n.dos_date[15:8]    = byte_s1;
						6'd16: fld_n.crc[7:0]          = byte_s1;
						6'd17: fld_n.crc[15:8]         = byte_s1;
						6'd18: fld_n.crc[23:16]        = byte_s1;
						6'd19: fld_n.crc[31:24]        = byte_s1;
						6'd20: fld_n.packed_size[7:0]  = byte_s1;
						6'd21: fld_n.packed_size[15:8] = byte_s1;
						6'd22: fld_n.packed_size[23:16] = byte_s1;
						6'd23: fld_n.packed_size[31:24] = byte_s1;
						6'd24: fld_n.plain_size[7:0]   = byte_s1;
						6'd25: fld_n.plain_size[15:8]  = byte_s1;
						6'd26: fld_n.plain_size[23:16] = byte_s1;
						6'd27: fld_n.plain_size[31:24] = byte_s1;
						6'd28: fld_n.name_len[7:0]     = byte_s1;
						6'd29: fld_n.name_len[15:8]    = byte_s1;
						6'd30: fld_n.extra_len[7:0]    = byte_s1;
						6'd31: fld_n.extra_len[15:8]   = byte_s1;
						6'd32: fld_n.comment_len[7:0]  = byte_s1;
						6'd33: fld_n.comment_len[15:8] = byte_s1;
						6'd42: fld_n.offset[7:0]       = byte_s1;
						6'd43: fld_n.offset[15:8]      = byte_s1;
						6'd44: fld_n.offset[23:16]     = byte_s1;
						6'd45: fld_n.offset[31:24]     = byte_s1;
						default: ;
					endcase
				end

				// header word on the last fixed byte, then name bytes
				if (pos_w == SUM_W'(HDR_LEN - 1)) begin
					va                  = 1'b1;
					res_a.kind          = KIND_HEADER;
					res_a.method        = fld_n.method;
					res_a.dos_time      = fld_n.dos_time;
					res_a.dos_date      = fld_n.dos_date;
					res_a.crc_value     = fld_n.crc;
					res_a.packed_size   = fld_n.packed_size;
					res_a.plain_size    = fld_n.plain_size;
					res_a.name_len      = fld_n.name_len;
					res_a.header_offset = fld_n.offset;
				end else if (pos_w >= SUM_W'(HDR_LEN) && pos_w < name_end) begin
					va              = 1'b1;
					res_a.kind      = KIND_NAME;
					res_a.name_char = byte_s1;
					res_a.last_char = (pos_w == name_end - SUM_W'(1));
				end

				total = SUM_W'(HDR_LEN) + SUM_W'(fld_n.name_len) + SUM_W'(fld_n.extra_len)
					+ SUM_W'(fld_n.comment_len);

				// saturating directory byte count
				dir_pos_n = (dir_pos_q != '1) ? dir_pos_q + 32'd1 : dir_pos_q;

				if (pos_w >= SUM_W'(HDR_LEN - 1) && pos_w + SUM_W'(1) >= total) begin
					rec_pos_n = '0;
					ent_n     = ent_q + 16'd1;
					if (ent_n >= entry_limit_q || dir_pos_n >= dir_bytes_q) begin
						fin_n      = 1'b1;
						vb         = 1'b1;
						res_b.kind = KIND_DONE;
					end
				end else begin
					rec_pos_n = rec_pos_q + POS_W'(1);
					if (dir_pos_n >= dir_bytes_q) begin
						fail_n     = 1'b1;
						vb         = 1'b1;
						res_b.kind = KIND_TRUNC;
					end
				end
			end
		end

		push_first = va ? res_a : res_b;
		npush      = {1'b0, va} + {1'b0, vb};
	end

	// Configuration, input register and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_limit_q <= '0;
			dir_bytes_q   <= '0;
			v_s1          <= 1'b0;
			rec_pos_q     <= '0;
			dir_pos_q     <= '0;
			ent_q         <= '0;
			sig_q         <= '0;
			fld_q         <= '0;
			fin_q         <= 1'b0;
			fail_q        <= 1'b0;
		end else begin
			if (byte_in.ready) begin
				v_s1 <= byte_in.valid;
			end
			if (wr_en && wr_index == REG_DIRECTORY_BYTES) begin
				dir_bytes_q <= wr_data;
			end
			if (restart) begin
				entry_limit_q <= wr_data[15:0];
				rec_pos_q     <= '0;
				dir_pos_q     <= '0;
				ent_q         <= '0;
				sig_q         <= '0;
				fld_q         <= '0;
				fin_q         <= 1'b0;
				fail_q        <= 1'b0;
			end else begin
				rec_pos_q <= rec_pos_n;
				dir_pos_q <= dir_pos_n;
				ent_q     <= ent_n;
				sig_q     <= sig_n;
				fld_q     <= fld_n;
				fin_q     <= fin_n;
				fail_q    <= fail_n;
			end
		end
	end

	// Input byte payload
	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (npush != 2'd0) begin
			q_mem[wp_q] <= push_first;
		end
		if (npush == 2'd2) begin
			q_mem[wp_q + QPTR_W'(1)] <= res_b;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(npush);
			rp_q  <= rp_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(npush) - QCNT_W'(pop);
		end
	end

	// Output word from the queue head
	assign entry_out.valid         = (cnt_q != '0);
	assign entry_out.kind          = q_mem[rp_q].kind;
	assign entry_out.method        = q_mem[rp_q].method;
	assign entry_out.dos_time      = q_mem[rp_q].dos_time;
	assign entry_out.dos_date      = q_mem[rp_q].dos_date;
	assign entry_out.crc_value     = q_mem[rp_q].crc_value;
	assign entry_out.packed_size   = q_mem[rp_q].packed_size;
	assign entry_out.plain_size    = q_mem[rp_q].plain_size;
	assign entry_out.name_len      = q_mem[rp_q].name_len;
	assign entry_out.header_offset = q_mem[rp_q].header_offset;
	assign entry_out.name_char     = q_mem[rp_q].name_char;
	assign entry_out.last_char     = q_mem[rp_q].last_char;

	// Queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	// Two results from one byte only ever end the parse
	a_two_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(npush == 2'd2) && !restart |=> (fin_q || fail_q))
		else $error("double result without end of parse");

	// Held byte stays put until it is decoded
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(byte_s1))
		else $error("input register lost a byte");

	// Nothing is emitted once parsing has ended
	a_quiet_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q || fail_q) |-> (npush == 2'd0))
		else $error("result after end of parse");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;
	import zcdp_pkg::*;

	typedef logic [7:0] octet_t;

	localparam int TOTAL_ITEMS   = 1550;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	reg_index_t  wr_index;
	logic [31:0] wr_data;

	zcdp_in_if  in_ch();
	zcdp_out_if out_ch();

	zip_central_directory_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.byte_in   (in_ch),
		.entry_out (out_ch)
	);

	always #4 clk = ~clk;

	// Stall odds, in percent, for each side
	int send_idle_pct = 18;
	int recv_idle_pct = 87;
	int mismatch_count = 0;
	// Words handed to the block so far, ignored ones included
	int sent_items = 0;

	// Parser model: registers, walk state, captured header
	logic [15:0] limit_reg;
	logic [31:0] size_reg;
	logic [17:0] parse_pos;
	logic [31:0] dir_count;
	logic [15:0] entries_done;
	logic [31:0] sig_shift;
	fields_t     captured;
	logic        parse_done;
	logic        parse_failed;

	// Result words still owed by the block, oldest first
	result_t entries_due[$];

	function automatic void clear_parse();
		parse_pos = '0;
		dir_count = '0;
		entries_done = '0;
		sig_shift = '0;
		captured = '0;
		parse_done = 1'b0;
		parse_failed = 1'b0;
	endfunction

	function automatic void push_kind(kind_t k);
		result_t r;
		r = '0;
		r.kind = k;
		entries_due.push_back(r);
	endfunction

	function automatic int record_len(fields_t f);
		return HDR_LEN + int'(f.name_len) + int'(f.extra_len) + int'(f.comment_len);
	endfunction

	// Advance the model by one directory byte and queue what it emits
	function automatic void parse_byte(octet_t b);
		int p;
		int body;
		bit complete;
		result_t r;
		p = int'(parse_pos);
		complete = 1'b0;
		if (parse_done || parse_failed) begin
			return;
		end
		if (p == 0 && (entries_done >= limit_reg || dir_count >= size_reg)) begin
			parse_done = 1'b1;
			push_kind(KIND_DONE);
			return;
		end

		// signature and field capture, little-endian
		if (p < 4) begin
			sig_shift = {b, sig_shift[31:8]};
			if (p == 3 && sig_shift != CD_SIGNATURE) begin
				parse_failed = 1'b1;
				push_kind(KIND_BAD_SIG);
				return;
			end
		end else if (p >= 10 && p < 12) begin
			captured.method[8*(p-10) +: 8] = b;
		end else if (p >= 12 && p < 14) begin
			captured.dos_time[8*(p-12) +: 8] = b;
		end else if (p >= 14 && p < 16) begin
			captured.dos_date[8*(p-14) +: 8] = b;
		end else if (p >= 16 && p < 20) begin
			captured.crc[8*(p-16) +: 8] = b;
		end else if (p >= 20 && p < 24) begin
			captured.packed_size[8*(p-20) +: 8] = b;
		end else if (p >= 24 && p < 28) begin
			captured.plain_size[8*(p-24) +: 8] = b;
		end else if (p >= 28 && p < 30) begin
			captured.name_len[8*(p-28) +: 8] = b;
		end else if (p >= 30 && p < 32) begin
			captured.extra_len[8*(p-30) +: 8] = b;
		end else if (p >= 32 && p < 34) begin
			captured.comment_len[8*(p-32) +: 8] = b;
		end else if (p >= 42 && p < 46) begin
			captured.offset[8*(p-42) +: 8] = b;
		end

		// header word on the last fixed byte, then one word per name byte
		if (p == HDR_LEN - 1) begin
			r = '0;
			r.kind = KIND_HEADER;
			r.method = captured.method;
			r.dos_time = captured.dos_time;
			r.dos_date = captured.dos_date;
			r.crc_value = captured.crc;
			r.packed_size = captured.packed_size;
			r.plain_size = captured.plain_size;
			r.name_len = captured.name_len;
			r.header_offset = captured.offset;
			entries_due.push_back(r);
		end else if (p >= HDR_LEN && p < HDR_LEN + int'(captured.name_len)) begin
			r = '0;
			r.kind = KIND_NAME;
			r.name_char = b;
			r.last_char = (p == HDR_LEN - 1 + int'(captured.name_len));
			entries_due.push_back(r);
		end

		if (p >= HDR_LEN - 1) begin
			body = record_len(captured);
			complete = (p + 1 >= body);
		end
		if (dir_count != 32'hffff_ffff) begin
			dir_count++;
		end

		// end of record, or truncation when the region runs out mid-record
		if (complete) begin
			parse_pos = '0;
			entries_done = entries_done + 16'd1;
			if (entries_done >= limit_reg || dir_count >= size_reg) begin
				parse_done = 1'b1;
				push_kind(KIND_DONE);
			end
		end else begin
			parse_pos = 18'(p + 1);
			if (dir_count >= size_reg) begin
				parse_failed = 1'b1;
				push_kind(KIND_TRUNC);
			end
		end
	endfunction

	// Random header contents with the given variable-field lengths
	function automatic fields_t make_fields(int name_n, int extra_n, int comment_n);
		fields_t f;
		f.method = 16'($urandom);
		f.dos_time = 16'($urandom);
		f.dos_date = 16'($urandom);
		f.crc = $urandom;
		f.packed_size = $urandom;
		f.plain_size = $urandom;
		f.name_len = 16'(name_n);
		f.extra_len = 16'(extra_n);
		f.comment_len = 16'(comment_n);
		f.offset = $urandom;
		return f;
	endfunction

	// Serialize one record; stops once the stream holds cap bytes
	function automatic void append_record(ref octet_t dir[$], input fields_t f,
			input logic [31:0] sig, input int cap);
		logic [8*HDR_LEN-1:0] raw;
		int body;
		for (int i = 0; i < HDR_LEN; i++) begin
			raw[8*i +: 8] = 8'($urandom);
		end
		raw[0 +: 32] = sig;
		raw[80 +: 16] = f.method;
		raw[96 +: 16] = f.dos_time;
		raw[112 +: 16] = f.dos_date;
		raw[128 +: 32] = f.crc;
		raw[160 +: 32] = f.packed_size;
		raw[192 +: 32] = f.plain_size;
		raw[224 +: 16] = f.name_len;
		raw[240 +: 16] = f.extra_len;
		raw[256 +: 16] = f.comment_len;
		raw[336 +: 32] = f.offset;
		for (int i = 0; i < HDR_LEN && dir.size() < cap; i++) begin
			dir.push_back(raw[8*i +: 8]);
		end
		body = int'(f.name_len) + int'(f.extra_len) + int'(f.comment_len);
		for (int i = 0; i < body && dir.size() < cap; i++) begin
			dir.push_back(8'($urandom));
		end
	endfunction

	// Send one word; returns at the accepting edge, valid left high
	task automatic send_byte(input octet_t b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		sent_items++;
		parse_byte(b);
	endtask

	task automatic send_stream(input octet_t bytes[$]);
		foreach (bytes[i]) begin
			send_byte(bytes[i]);
		end
	endtask

	// Drop valid, drain every owed word, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (entries_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == REG_ENTRY_LIMIT) begin
			limit_reg = value[15:0];
			clear_parse();
		end else begin
			size_reg = value;
		end
	endtask

	// Size first, then the limit, which also restarts the parser
	task automatic start_directory(input logic [15:0] lim, input logic [31:0] size);
		wait_idle();
		write_reg(REG_DIRECTORY_BYTES, size);
		write_reg(REG_ENTRY_LIMIT, {16'($urandom), lim});
	endtask

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			mismatch_count++;
		end
	endfunction

	// Receiver stalls
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Compare every accepted result word with the oldest one owed
	always @(posedge clk) begin
		result_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (entries_due.size() == 0) begin
				$error("kind: expected no word, actual %0d", out_ch.kind);
				mismatch_count++;
			end else begin
				want = entries_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(out_ch.kind));
				check_field("method", 32'(want.method), 32'(out_ch.method));
				check_field("dos_time", 32'(want.dos_time), 32'(out_ch.dos_time));
				check_field("dos_date", 32'(want.dos_date), 32'(out_ch.dos_date));
				check_field("crc_value", want.crc_value, out_ch.crc_value);
				check_field("packed_size", want.packed_size, out_ch.packed_size);
				check_field("plain_size", want.plain_size, out_ch.plain_size);
				check_field("name_len", 32'(want.name_len), 32'(out_ch.name_len));
				check_field("header_offset", want.header_offset, out_ch.header_offset);
				check_field("name_char", 32'(want.name_char), 32'(out_ch.name_char));
				check_field("last_char", 32'(want.last_char), 32'(out_ch.last_char));
			end
		end
	end

	// Zero limit, zero size, size or limit reached at a record boundary
	task automatic test_end_conditions();
		octet_t dir[$];
		fields_t f;
		start_directory(16'd0, 32'd100);
		send_byte(8'h50);
		send_byte(8'h4b);
		start_directory(16'd7, 32'd0);
		send_byte(8'hff);

		f = make_fields(0, 0, 0);
		append_record(dir, f, CD_SIGNATURE, HDR_LEN);
		start_directory(16'd3, 32'(HDR_LEN));
		send_stream(dir);

		// size lowered below the consumed count while parked at a record start
		dir.delete();
		f = make_fields(2, 0, 1);
		append_record(dir, f, CD_SIGNATURE, 1000);
		start_directory(16'd3, 32'd1000);
		send_stream(dir);
		wait_idle();
		write_reg(REG_DIRECTORY_BYTES, 32'd10);
		send_byte(8'h50);

		start_directory(16'd1, 32'd1000);
		send_stream(dir);
	endtask

	// All-ones and all-zero headers, then the widest register settings
	task automatic test_field_extremes();
		octet_t dir[$];
		fields_t f;
		fields_t g;
		f = '1;
		f.name_len = 16'd3;
		f.extra_len = 16'd2;
		f.comment_len = 16'd1;
		g = '0;
		append_record(dir, f, CD_SIGNATURE, 1000);
		append_record(dir, g, CD_SIGNATURE, 1000);
		start_directory(16'd2, 32'(record_len(f) + record_len(g)));
		send_stream(dir);

		dir.delete();
		f = make_fields(1, 0, 0);
		append_record(dir, f, CD_SIGNATURE, 1000);
		append_record(dir, f, CD_SIGNATURE, record_len(f) + 5);
		start_directory(16'hffff, 32'hffff_ffff);
		send_stream(dir);
	endtask

	task automatic test_bad_signature();
		octet_t dir[$];
		fields_t f;
		// second record has a wrong top byte; trailing bytes are dropped
		f = make_fields(1, 1, 1);
		append_record(dir, f, CD_SIGNATURE, 1000);
		append_record(dir, f, CD_SIGNATURE ^ 32'h8000_0000, 1000);
		start_directory(16'd3, 32'd1000);
		send_stream(dir);

		// wrong first byte is only flagged on the fourth
		dir.delete();
		append_record(dir, f, CD_SIGNATURE ^ 32'h0000_0001, 1000);
		start_directory(16'd1, 32'd1000);
		send_stream(dir);
	endtask

	task automatic test_truncation();
		octet_t dir[$];
		fields_t f;
		fields_t g;
		// region ends on the last fixed byte: header word plus truncation
		f = make_fields(2, 0, 0);
		append_record(dir, f, CD_SIGNATURE, 1000);
		start_directory(16'd1, 32'(HDR_LEN));
		send_stream(dir);

		// region ends inside the name: name word plus truncation
		dir.delete();
		g = make_fields(0, 1, 0);
		f = make_fields(4, 0, 0);
		append_record(dir, g, CD_SIGNATURE, 1000);
		append_record(dir, f, CD_SIGNATURE, 1000);
		start_directory(16'd2, 32'(record_len(g) + HDR_LEN + 2));
		send_stream(dir);

		// region ends inside the fixed header
		dir.delete();
		append_record(dir, f, CD_SIGNATURE, 1000);
		start_directory(16'd1, 32'd10);
		send_stream(dir);
	endtask

	// Sender holds off mid-header and mid-name until the block has drained
	task automatic test_pause_mid_record();
		octet_t dir[$];
		fields_t f;
		f = make_fields(5, 1, 2);
		append_record(dir, f, CD_SIGNATURE, 1000);
		start_directory(16'd1, 32'(record_len(f)));
		for (int i = 0; i < dir.size(); i++) begin
			if (i == 20 || i == HDR_LEN + 2) begin
				wait_idle();
			end
			send_byte(dir[i]);
		end
	endtask

	// Mostly well-formed directories; some truncated, corrupted or pure noise
	task automatic test_random_directories();
		octet_t dir[$];
		fields_t recs[$];
		fields_t f;
		int n_rec;
		int sel;
		int total;
		int cap;
		int bad_at;
		int base;
		logic [15:0] lim;
		logic [31:0] size;
		logic [31:0] sig;
		base = sent_items;
		while (sent_items < TOTAL_ITEMS) begin
			if (sent_items - base < (TOTAL_ITEMS - base) / 3) begin
				send_idle_pct = 18;
				recv_idle_pct = 87;
			end else if (sent_items - base < 2 * (TOTAL_ITEMS - base) / 3) begin
				send_idle_pct = 87;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			dir.delete();
			recs.delete();
			sel = $urandom_range(99);
			n_rec = $urandom_range(1, 4);
			total = 0;
			for (int i = 0; i < n_rec; i++) begin
				if (sel >= 75 && sel < 85 && i == n_rec - 1) begin
					f = make_fields($urandom_range(16'h8000, 16'hffff),
						$urandom_range(16'hffff), $urandom_range(16'hffff));
				end else if ($urandom_range(9) == 0) begin
					f = make_fields($urandom_range(20, 40), $urandom_range(8), $urandom_range(8));
				end else begin
					f = make_fields($urandom_range(8), $urandom_range(3), $urandom_range(3));
				end
				recs.push_back(f);
				total += record_len(f);
			end

			// pick how the directory ends
			lim = 16'(n_rec);
			size = 32'(total);
			cap = total;
			if (sel < 60) begin
				case ($urandom_range(4))
					0: lim = 16'(n_rec + $urandom_range(1, 3));
					1: size = 32'(total + $urandom_range(1, 60));
					2: begin
						lim = 16'hffff;
						size = 32'hffff_ffff;
					end
					3: lim = 16'($urandom_range(0, n_rec - 1));
					default: ;
				endcase
			end else if (sel < 75) begin
				size = $urandom_range(1, total - 1);
			end else if (sel < 85) begin
				// huge last record, cut off early
				size = 32'(total - record_len(recs[n_rec - 1]) + $urandom_range(1, 60));
				cap = int'(size) + 4;
			end

			bad_at = (sel >= 85 && sel < 93) ? $urandom_range(0, n_rec - 1) : -1;
			for (int i = 0; i < n_rec; i++) begin
				sig = (i == bad_at) ? CD_SIGNATURE ^ (32'h1 << $urandom_range(31)) : CD_SIGNATURE;
				append_record(dir, recs[i], sig, cap);
			end

			if (sel >= 93) begin
				dir.delete();
				if ($urandom_range(1) == 1) begin
					for (int i = 0; i < 4; i++) begin
						dir.push_back(CD_SIGNATURE[8*i +: 8]);
					end
				end
				repeat ($urandom_range(1, 60)) dir.push_back(8'($urandom));
				lim = 16'($urandom_range(3));
				size = $urandom_range(100);
			end
			repeat ($urandom_range(3)) dir.push_back(8'($urandom));

			start_directory(lim, size);
			send_stream(dir);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_ENTRY_LIMIT;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		out_ch.ready = 1'b0;
		limit_reg = '0;
		size_reg = '0;
		clear_parse();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_end_conditions();
		test_field_extremes();
		test_bad_signature();
		test_truncation();
		test_pause_mid_record();
		test_random_directories();

		wait_idle();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$error("timeout with %0d result words still owed", entries_due.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
